### hw/rtl/lrrd_pkg.sv
// Shared types, constants and the echo text for the range reply decoder.
package lrrd_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W       = 10;

	localparam logic [3:0] ECHO_LEN   = 4'd10;
	localparam logic [3:0] ECHO_CHECK = 4'd9;
	localparam logic [7:0] LF_CHAR    = 8'h0A;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] STATUS_OK  = 8'h30;

	localparam logic [2:0] KIND_READING = 3'd0;
	localparam logic [2:0] KIND_BEYOND  = 3'd1;
	localparam logic [2:0] KIND_DONE    = 3'd2;
	localparam logic [2:0] KIND_ECHO    = 3'd3;
	localparam logic [2:0] KIND_STATUS  = 3'd4;

	localparam logic FUNC_START = 1'b0;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ECHO,
		PH_STATUS,
		PH_STAT_LF,
		PH_PAIR_A,
		PH_LF_SEEN,
		PH_PAIR_B,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [11:0]      reading;
		logic [IDX_W-1:0] reading_index;
		logic [7:0]       status_char;
		logic             last;
	} out_item_t;

	typedef struct packed {
		phase_t           phase;
		logic [3:0]       echo_count;
		logic             echo_bad;
		logic [7:0]       first_char;
		logic [CNT_W-1:0] count_read;
	} dec_state_t;

	function automatic logic [7:0] echo_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h47;
			4'd1:    c = 8'h30;
			4'd2:    c = 8'h30;
			4'd3:    c = 8'h30;
			4'd4:    c = 8'h37;
			4'd5:    c = 8'h36;
			4'd6:    c = 8'h38;
			4'd7:    c = 8'h30;
			4'd8:    c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/lrrd_step.sv
// Per-byte decode step: next parser state and the result for one item.
module lrrd_step (
	input  lrrd_pkg::dec_state_t st,
	input  lrrd_pkg::in_item_t   item,
	output lrrd_pkg::dec_state_t st_next,
	output logic                 res_valid,
	output lrrd_pkg::out_item_t  res
);

	logic [3:0]                 echo_inc;
	logic                       echo_miss;
	logic [5:0]                 hi_sub;
	logic [5:0]                 lo_sub;
	logic [11:0]                value;
	logic                       room;
	logic [lrrd_pkg::IDX_W-1:0] idx_sat;

	assign echo_inc  = st.echo_count + 4'd1;
	assign echo_miss = (st.echo_count < lrrd_pkg::ECHO_CHECK) &&
	                   (item.byte_value != lrrd_pkg::echo_char(st.echo_count));
	assign hi_sub    = 6'(st.first_char - lrrd_pkg::DIGIT_BASE);
	assign lo_sub    = 6'(item.byte_value - lrrd_pkg::DIGIT_BASE);
	assign value     = {hi_sub, lo_sub};
	assign room      = st.count_read < lrrd_pkg::CNT_W'(lrrd_pkg::MAX_SAMPLES);
	assign idx_sat   = lrrd_pkg::IDX_W'(lrrd_pkg::MAX_SAMPLES - 1);

	always_comb begin
		st_next = st;
		if (item.func == lrrd_pkg::FUNC_START) begin
			st_next.phase      = lrrd_pkg::PH_ECHO;
			st_next.echo_count = '0;
			st_next.echo_bad   = 1'b0;
			st_next.first_char = '0;
			st_next.count_read = '0;
		end else begin
			unique case (st.phase)
				lrrd_pkg::PH_ECHO: begin
					st_next.echo_count = echo_inc;
					st_next.echo_bad   = st.echo_bad | echo_miss;
					if (echo_inc >= lrrd_pkg::ECHO_LEN) begin
						st_next.phase = (st.echo_bad | echo_miss) ?
						                lrrd_pkg::PH_HALT : lrrd_pkg::PH_STATUS;
					end
				end
				lrrd_pkg::PH_STATUS: begin
					st_next.first_char = item.byte_value;
					st_next.phase      = lrrd_pkg::PH_STAT_LF;
				end
				lrrd_pkg::PH_STAT_LF: begin
					st_next.phase = (st.first_char != lrrd_pkg::STATUS_OK) ?
					                lrrd_pkg::PH_HALT : lrrd_pkg::PH_PAIR_A;
				end
				lrrd_pkg::PH_PAIR_A: begin
					if (item.byte_value == lrrd_pkg::LF_CHAR) begin
						st_next.phase = lrrd_pkg::PH_LF_SEEN;
					end else begin
						st_next.first_char = item.byte_value;
						st_next.phase      = lrrd_pkg::PH_PAIR_B;
					end
				end
				lrrd_pkg::PH_LF_SEEN: begin
					if (item.byte_value == lrrd_pkg::LF_CHAR) begin
						st_next.phase = lrrd_pkg::PH_IDLE;
					end else begin
						st_next.first_char = item.byte_value;
						st_next.phase      = lrrd_pkg::PH_PAIR_B;
					end
				end
				lrrd_pkg::PH_PAIR_B: begin
					st_next.phase = lrrd_pkg::PH_PAIR_A;
					if (room) begin
						st_next.count_read = st.count_read + lrrd_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (item.func != lrrd_pkg::FUNC_START) begin
			unique case (st.phase)
				lrrd_pkg::PH_ECHO: begin
					if ((echo_inc >= lrrd_pkg::ECHO_LEN) && (st.echo_bad | echo_miss)) begin
						res_valid = 1'b1;
						res.kind  = lrrd_pkg::KIND_ECHO;
						res.last  = 1'b1;
					end
				end
				lrrd_pkg::PH_STAT_LF: begin
					if (st.first_char != lrrd_pkg::STATUS_OK) begin
						res_valid       = 1'b1;
						res.kind        = lrrd_pkg::KIND_STATUS;
						res.status_char = st.first_char;
						res.last        = 1'b1;
					end
				end
				lrrd_pkg::PH_LF_SEEN: begin
					if (item.byte_value == lrrd_pkg::LF_CHAR) begin
						res_valid = 1'b1;
						res.kind  = lrrd_pkg::KIND_DONE;
						res.last  = 1'b1;
					end
				end
				lrrd_pkg::PH_PAIR_B: begin
					res_valid   = 1'b1;
					res.reading = value;
					if (room) begin
						res.kind          = lrrd_pkg::KIND_READING;
						res.reading_index = st.count_read[lrrd_pkg::IDX_W-1:0];
					end else begin
						res.kind          = lrrd_pkg::KIND_BEYOND;
						res.reading_index = idx_sat;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hw/rtl/laser_range_reply_decoder.sv
// Top level of the range reply decoder: input register, decode step, result register.
// A byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle unless stalled; the parser state loop sets this.
// A result stalled in the output register holds the input register and blocks new bytes.
// Reset (arst_n low, asynchronous) clears the valids and puts the parser in idle.
module laser_range_reply_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lrrd_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output lrrd_pkg::out_item_t result
);

	logic                 valid_s1;
	lrrd_pkg::in_item_t   item_s1;
	logic                 out_free;
	logic                 adv;
	lrrd_pkg::dec_state_t st_q;
	lrrd_pkg::dec_state_t st_next;
	logic                 res_valid;
	lrrd_pkg::out_item_t  res;
	logic                 result_valid_q;
	lrrd_pkg::out_item_t  result_q;

	assign out_free   = !result_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	lrrd_step u_step (
		.st        (st_q),
		.item      (item_s1),
		.st_next   (st_next),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: lrrd_pkg::PH_IDLE, echo_count: '0, echo_bad: 1'b0,
			          first_char: '0, count_read: '0};
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### verif/testbench.sv
// Self-checking testbench for the range reply decoder: directed table, random replies, scoreboard.
`timescale 1ns / 1ps

module testbench;

	localparam logic            FUNC_BYTE      = ~lrrd_pkg::FUNC_START;
	localparam logic [8*9-1:0]  ECHO_STR       = "G00076801";
	localparam int              RANDOM_ITEMS   = 650;
	localparam int              HOLD_OFF       = 300;
	localparam int              WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		lrrd_pkg::in_item_t  it;
		logic                typed;
		lrrd_pkg::out_item_t want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	lrrd_pkg::in_item_t  item;
	logic                result_valid;
	logic                result_stall;
	lrrd_pkg::out_item_t result;

	// predictor state
	lrrd_pkg::phase_t           dec_phase     = lrrd_pkg::PH_IDLE;
	logic [3:0]                 echo_seen     = '0;
	logic                       echo_wrong    = 1'b0;
	logic [7:0]                 held_char     = '0;
	logic [lrrd_pkg::CNT_W-1:0] readings_done = '0;

	lrrd_pkg::out_item_t awaited_results [$];
	stim_row_t           directed_rows [$];
	stim_row_t           stim_q [$];
	int                  reply_left;
	int                  items_in   = 0;
	int                  mismatches = 0;
	bit                  stim_done  = 1'b0;
	bit                  held_off   = 1'b0;

	laser_range_reply_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic stim_row_t byte_row(input logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.it.func = FUNC_BYTE;
		r.it.byte_value = b;
		return r;
	endfunction

	function automatic stim_row_t start_row(input logic [7:0] b);
		stim_row_t r;
		r = byte_row(b);
		r.it.func = lrrd_pkg::FUNC_START;
		return r;
	endfunction

	function automatic stim_row_t byte_chk(input logic [7:0] b, input lrrd_pkg::out_item_t w);
		stim_row_t r;
		r = byte_row(b);
		r.typed = 1'b1;
		r.want = w;
		return r;
	endfunction

	function automatic bit decode_byte(input lrrd_pkg::in_item_t it,
			output lrrd_pkg::out_item_t res);
		logic [5:0] hi;
		logic [5:0] lo;
		logic [7:0] b;
		res = '0;
		b = it.byte_value;
		if (it.func == lrrd_pkg::FUNC_START) begin
			dec_phase = lrrd_pkg::PH_ECHO;
			echo_seen = '0;
			echo_wrong = 1'b0;
			held_char = '0;
			readings_done = '0;
			return 1'b0;
		end
		case (dec_phase)
			lrrd_pkg::PH_ECHO: begin
				if (echo_seen < lrrd_pkg::ECHO_CHECK && b != ECHO_STR[8*(8-echo_seen) +: 8])
					echo_wrong = 1'b1;
				echo_seen++;
				if (echo_seen >= lrrd_pkg::ECHO_LEN) begin
					if (echo_wrong) begin
						dec_phase = lrrd_pkg::PH_HALT;
						res.kind = lrrd_pkg::KIND_ECHO;
						res.last = 1'b1;
						return 1'b1;
					end
					dec_phase = lrrd_pkg::PH_STATUS;
				end
			end
			lrrd_pkg::PH_STATUS: begin
				held_char = b;
				dec_phase = lrrd_pkg::PH_STAT_LF;
			end
			lrrd_pkg::PH_STAT_LF: begin
				if (held_char != lrrd_pkg::STATUS_OK) begin
					dec_phase = lrrd_pkg::PH_HALT;
					res.kind = lrrd_pkg::KIND_STATUS;
					res.status_char = held_char;
					res.last = 1'b1;
					return 1'b1;
				end
				dec_phase = lrrd_pkg::PH_PAIR_A;
			end
			lrrd_pkg::PH_PAIR_A: begin
				if (b == lrrd_pkg::LF_CHAR) begin
					dec_phase = lrrd_pkg::PH_LF_SEEN;
				end else begin
					held_char = b;
					dec_phase = lrrd_pkg::PH_PAIR_B;
				end
			end
			lrrd_pkg::PH_LF_SEEN: begin
				if (b == lrrd_pkg::LF_CHAR) begin
					dec_phase = lrrd_pkg::PH_IDLE;
					res.kind = lrrd_pkg::KIND_DONE;
					res.last = 1'b1;
					return 1'b1;
				end
				held_char = b;
				dec_phase = lrrd_pkg::PH_PAIR_B;
			end
			lrrd_pkg::PH_PAIR_B: begin
				hi = 6'(held_char - lrrd_pkg::DIGIT_BASE);
				lo = 6'(b - lrrd_pkg::DIGIT_BASE);
				res.reading = {hi, lo};
				dec_phase = lrrd_pkg::PH_PAIR_A;
				if (readings_done < lrrd_pkg::MAX_SAMPLES) begin
					res.kind = lrrd_pkg::KIND_READING;
					res.reading_index = lrrd_pkg::IDX_W'(readings_done);
					readings_done++;
				end else begin
					res.kind = lrrd_pkg::KIND_BEYOND;
					res.reading_index = lrrd_pkg::IDX_W'(lrrd_pkg::MAX_SAMPLES - 1);
				end
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic logic [7:0] pair_char(input bit clean);
		if (clean || $urandom_range(0, 9) != 0)
			return 8'($urandom_range(8'h30, 8'h6F));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		if (reply_left != 0) begin
			stim_q.push_back(byte_row(b));
			reply_left--;
		end
	endtask

	// clean: well formed throughout, no truncation
	task automatic queue_reply(input int pairs, input bit clean);
		int bad_at;
		stim_q.push_back(start_row(8'($urandom_range(0, 255))));
		reply_left = (!clean && $urandom_range(0, 19) == 0) ?
			$urandom_range(1, 30) : (1 << 30);
		bad_at = (!clean && $urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : -1;
		for (int i = 0; i < 9; i++)
			queue_byte(i == bad_at ? 8'($urandom_range(0, 255)) : ECHO_STR[8*(8-i) +: 8]);
		queue_byte(8'($urandom_range(0, 255)));
		queue_byte((clean || $urandom_range(0, 7) != 0) ?
			lrrd_pkg::STATUS_OK : 8'($urandom_range(0, 255)));
		queue_byte((clean || $urandom_range(0, 9) != 0) ?
			lrrd_pkg::LF_CHAR : 8'($urandom_range(0, 255)));
		for (int p = 0; p < pairs; p++) begin
			if (!clean && $urandom_range(0, 6) == 0)
				queue_byte(lrrd_pkg::LF_CHAR);
			queue_byte(pair_char(clean));
			queue_byte(pair_char(clean));
		end
		queue_byte(lrrd_pkg::LF_CHAR);
		queue_byte(lrrd_pkg::LF_CHAR);
	endtask

	function automatic int pick_gap();
		int r;
		if ((items_in % 256) >= 200)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic bit same_result(input lrrd_pkg::out_item_t a,
			input lrrd_pkg::out_item_t b);
		return a.kind === b.kind && a.reading === b.reading &&
			a.reading_index === b.reading_index && a.status_char === b.status_char &&
			a.last === b.last;
	endfunction

	initial begin : sender
		stim_row_t           r;
		lrrd_pkg::out_item_t got;
		int                  counted;
		int                  base;
		int                  gap;
		bit                  long_done;
		item_valid = 1'b0;
		item = '0;
		counted = 0;
		long_done = 1'b0;
		directed_rows = '{
			byte_row(8'hFF),
			start_row(8'hA5),
			byte_row("G"), byte_row("0"), byte_row("0"), byte_row("0"), byte_row("7"),
			byte_row("6"), byte_row("8"), byte_row("0"), byte_row("1"),
			byte_row(8'h00),
			byte_row("0"),
			byte_row(8'hFF),
			byte_row("0"),
			byte_chk("0", lrrd_pkg::out_item_t'{lrrd_pkg::KIND_READING,
				12'd0, 10'd0, 8'd0, 1'b0}),
			byte_row("o"),
			byte_chk("o", lrrd_pkg::out_item_t'{lrrd_pkg::KIND_READING,
				12'd4095, 10'd1, 8'd0, 1'b0}),
			byte_row(lrrd_pkg::LF_CHAR),
			byte_row(8'hFF),
			byte_row(lrrd_pkg::LF_CHAR),
			byte_row(lrrd_pkg::LF_CHAR),
			byte_chk(lrrd_pkg::LF_CHAR, lrrd_pkg::out_item_t'{lrrd_pkg::KIND_DONE,
				12'd0, 10'd0, 8'd0, 1'b1}),
			byte_row(8'h47),
			start_row(8'h5A),
			byte_row("G"), byte_row("0"), byte_row("0"), byte_row("0"), byte_row("7"),
			byte_row("6"), byte_row("8"), byte_row("0"), byte_row("2"),
			byte_chk("1", lrrd_pkg::out_item_t'{lrrd_pkg::KIND_ECHO,
				12'd0, 10'd0, 8'd0, 1'b1}),
			byte_row("0"),
			start_row(8'h00),
			byte_row("G"), byte_row("0"), byte_row("0"), byte_row("0"), byte_row("7"),
			byte_row("6"), byte_row("8"), byte_row("0"), byte_row("1"),
			byte_row("X"),
			byte_row(8'hFF),
			byte_chk(lrrd_pkg::LF_CHAR, lrrd_pkg::out_item_t'{lrrd_pkg::KIND_STATUS,
				12'd0, 10'd0, 8'hFF, 1'b1})
		};
		foreach (directed_rows[i])
			stim_q.push_back(directed_rows[i]);
		while (counted < RANDOM_ITEMS) begin
			base = stim_q.size();
			if ($urandom_range(0, 99) < 6) begin
				repeat ($urandom_range(1, 3))
					stim_q.push_back(byte_row(8'($urandom_range(0, 255))));
			end else begin
				queue_reply(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(0, 10), 1'b0);
				counted += stim_q.size() - base;
			end
			if (!long_done && counted >= 250) begin
				long_done = 1'b1;
				queue_reply(lrrd_pkg::MAX_SAMPLES + 6, 1'b1);
			end
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		while (stim_q.size() > 0) begin
			gap = pick_gap();
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			r = stim_q.pop_front();
			item_valid <= 1'b1;
			item <= r.it;
			@(posedge clk);
			while (item_stall) @(posedge clk);
			items_in++;
			if (decode_byte(r.it, got))
				awaited_results.push_back(r.typed ? r.want : got);
		end
		item_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin : receiver
		int hold;
		hold = 0;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && items_in >= 400) begin
				held_off = 1'b1;
				hold = HOLD_OFF;
			end else if (hold == 0 && $urandom_range(0, 3) == 0) begin
				hold = pick_gap();
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		lrrd_pkg::out_item_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				if (mismatches < 10)
					$display("extra result: kind=%0d reading=%0d index=%0d status=%02h last=%0d",
						result.kind, result.reading, result.reading_index,
						result.status_char, result.last);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (!same_result(want, result)) begin
					if (mismatches < 10) begin
						$write("mismatch: expected kind=%0d reading=%0d index=%0d status=%02h",
							want.kind, want.reading, want.reading_index, want.status_char);
						$write(" last=%0d, got kind=%0d reading=%0d index=%0d", want.last,
							result.kind, result.reading, result.reading_index);
						$display(" status=%02h last=%0d", result.status_char, result.last);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : wrap_up
		wait (stim_done);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/lrrd_pkg.sv
hw/rtl/lrrd_step.sv
hw/rtl/laser_range_reply_decoder.sv
verif/testbench.sv
